@@ rtl/mcpt_pkg.sv @@
`default_nettype none

package mcpt_pkg;

	localparam int NUM_TIMERS = 16;
	localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

	localparam int OP_W     = 3;
	localparam int ID_W     = 4;
	localparam int PERIOD_W = 32;
	localparam int REPS_W   = 16;
	localparam int KIND_W   = 2;
	localparam int CNT_W    = 5;
	localparam int TICK_W   = 16;
	localparam int REM_MS_W = 32;

	localparam int DIV_STEPS = PERIOD_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic [APB_AW-3:0] REG_TICK_MS   = '0;
	localparam logic [TICK_W-1:0] TICK_MS_RESET = TICK_W'(10);

	localparam logic [OP_W-1:0] OP_TICK     = 3'd0;
	localparam logic [OP_W-1:0] OP_ARM      = 3'd1;
	localparam logic [OP_W-1:0] OP_DISARM   = 3'd2;
	localparam logic [OP_W-1:0] OP_PAUSE    = 3'd3;
	localparam logic [OP_W-1:0] OP_RESUME   = 3'd4;
	localparam logic [OP_W-1:0] OP_EXEC_NOW = 3'd5;
	localparam logic [OP_W-1:0] OP_QUERY    = 3'd6;

	localparam logic [KIND_W-1:0] KIND_REPLY  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_EXPIRE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd2;

	typedef struct packed {
		logic                active;
		logic                paused;
		logic [PERIOD_W-1:0] base;
		logic [PERIOD_W-1:0] rem;
		logic [REPS_W-1:0]   reps;
	} slot_t;

endpackage

`default_nettype wire

@@ rtl/mcpt_if.sv @@
`default_nettype none

interface mcpt_cmd_if;
	logic                          valid;
	logic                          ready;
	logic [mcpt_pkg::OP_W-1:0]     op;
	logic [mcpt_pkg::ID_W-1:0]     timer_id;
	logic [mcpt_pkg::PERIOD_W-1:0] period_ms;
	logic [mcpt_pkg::REPS_W-1:0]   repeat_count;
	logic                          fire_now;

	modport source (output valid, op, timer_id, period_ms, repeat_count, fire_now,
		input ready);
	modport sink (input valid, op, timer_id, period_ms, repeat_count, fire_now,
		output ready);
endinterface

interface mcpt_res_if;
	logic                          valid;
	logic                          ready;
	logic [mcpt_pkg::KIND_W-1:0]   kind;
	logic [mcpt_pkg::ID_W-1:0]     timer_id_res;
	logic                          ok;
	logic                          armed;
	logic [mcpt_pkg::REM_MS_W-1:0] remaining_ms;
	logic [mcpt_pkg::CNT_W-1:0]    active_count;
	logic                          last;

	modport source (output valid, kind, timer_id_res, ok, armed, remaining_ms,
		active_count, last, input ready);
	modport sink (input valid, kind, timer_id_res, ok, armed, remaining_ms,
		active_count, last, output ready);
endinterface

`default_nettype wire

@@ rtl/mcpt_cell.sv @@
`default_nettype none

module mcpt_cell (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            shift,
	input  wire mcpt_pkg::slot_t d,
	output mcpt_pkg::slot_t      q
);

	logic                          active_q;
	logic                          paused_q;
	logic [mcpt_pkg::PERIOD_W-1:0] base_q;
	logic [mcpt_pkg::PERIOD_W-1:0] rem_q;
	logic [mcpt_pkg::REPS_W-1:0]   reps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			paused_q <= 1'b0;
		end else if (shift) begin
			active_q <= d.active;
			paused_q <= d.paused;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			base_q <= d.base;
			rem_q  <= d.rem;
			reps_q <= d.reps;
		end
	end

	assign q = '{active: active_q, paused: paused_q, base: base_q, rem: rem_q, reps: reps_q};

endmodule

`default_nettype wire

@@ rtl/mcpt_div.sv @@
`default_nettype none

module mcpt_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [mcpt_pkg::PERIOD_W-1:0] dividend,
	input  wire logic [mcpt_pkg::TICK_W-1:0]   divisor,
	output logic                               done,
	output logic [mcpt_pkg::PERIOD_W-1:0]      quotient
);

	logic                           busy_q;
	logic                           done_q;
	logic [mcpt_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [mcpt_pkg::PERIOD_W-1:0]  dvd_q;
	logic [mcpt_pkg::TICK_W-1:0]    rem_q;
	logic [mcpt_pkg::TICK_W-1:0]    dsr_q;
	logic [mcpt_pkg::TICK_W:0]      trial;
	logic [mcpt_pkg::TICK_W:0]      diff;
	logic                           ge;

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, dvd_q[mcpt_pkg::PERIOD_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign ge    = (trial >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == mcpt_pkg::DIV_CNT_W'(mcpt_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= (divisor == '0) ? mcpt_pkg::TICK_W'(1) : divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[mcpt_pkg::TICK_W-1:0] : trial[mcpt_pkg::TICK_W-1:0];
			dvd_q <= {dvd_q[mcpt_pkg::PERIOD_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

`default_nettype wire

@@ rtl/multi_channel_periodic_timer_top.sv @@
// Each item walks the slot ring once, one slot record through the head cell per cycle.
// Arm and exec_now first run a bit-serial divide (period / tick length).
// Accept to first result: S_WALK, S_MUL, S_LOAD, then S_OUT; arm/exec_now pass S_DIV first.
// Input is taken only after the last result of the item before; a tick gives up to 16 results.
// Reset (arst_n low, asynchronous): all slots inactive and unpaused, tick_ms = 10, no result.
`default_nettype none

module multi_channel_periodic_timer_top (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	mcpt_cmd_if.sink                                 cmd,
	mcpt_res_if.source                               res,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [mcpt_pkg::APB_AW-1:0]         paddr,
	input  wire logic [mcpt_pkg::APB_DW-1:0]         pwdata,
	output logic      [mcpt_pkg::APB_DW-1:0]         prdata,
	output logic                                     pready
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_WALK,
		S_MUL,
		S_LOAD,
		S_OUT
	} state_t;

	state_t state_q;

	logic [mcpt_pkg::TICK_W-1:0]   tick_ms_q;
	logic [mcpt_pkg::OP_W-1:0]     op_q;
	logic [mcpt_pkg::ID_W-1:0]     id_q;
	logic [mcpt_pkg::REPS_W-1:0]   reps_q;
	logic                          fire_q;
	logic [mcpt_pkg::PERIOD_W-1:0] ticks_q;
	logic [mcpt_pkg::IDX_W-1:0]    step_q;
	logic [mcpt_pkg::CNT_W-1:0]    cnt_q;
	logic [mcpt_pkg::NUM_TIMERS-1:0] mask_q;
	logic                          ok_q;
	logic                          armed_q;
	logic [mcpt_pkg::PERIOD_W-1:0] qrem_q;
	logic [mcpt_pkg::PERIOD_W+mcpt_pkg::TICK_W-1:0] prod_q;

	logic                          res_valid_q;
	logic [mcpt_pkg::KIND_W-1:0]   kind_q;
	logic [mcpt_pkg::ID_W-1:0]     rid_q;
	logic                          rok_q;
	logic                          rarmed_q;
	logic [mcpt_pkg::REM_MS_W-1:0] rrem_q;
	logic [mcpt_pkg::CNT_W-1:0]    rcnt_q;
	logic                          rlast_q;

	mcpt_pkg::slot_t cell_q [mcpt_pkg::NUM_TIMERS];
	mcpt_pkg::slot_t head;
	mcpt_pkg::slot_t nxt;

	logic                          shift;
	logic                          cmd_acc;
	logic                          div_start;
	logic                          div_done;
	logic [mcpt_pkg::PERIOD_W-1:0] quot;
	logic                          sel;
	logic                          expire;
	logic                          hit_ok;
	logic                          hit_armed;
	logic [mcpt_pkg::PERIOD_W-1:0] dec;
	logic [mcpt_pkg::REPS_W-1:0]   reps_dec;
	logic [mcpt_pkg::NUM_TIMERS-1:0] nmask;
	logic [mcpt_pkg::IDX_W-1:0]    nidx;
	logic                          apb_wr;

	function automatic logic [mcpt_pkg::IDX_W-1:0] lowest_idx(
		input logic [mcpt_pkg::NUM_TIMERS-1:0] m);
		logic [mcpt_pkg::IDX_W-1:0] idx;
		idx = '0;
		for (int i = mcpt_pkg::NUM_TIMERS - 1; i >= 0; i--) begin
			if (m[i]) idx = mcpt_pkg::IDX_W'(i);
		end
		return idx;
	endfunction

	// config port
	assign pready = 1'b1;
	assign apb_wr = psel && penable && pwrite;
	assign prdata = (paddr[mcpt_pkg::APB_AW-1:2] == mcpt_pkg::REG_TICK_MS) ?
		mcpt_pkg::APB_DW'(tick_ms_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_ms_q <= mcpt_pkg::TICK_MS_RESET;
		end else if (apb_wr && paddr[mcpt_pkg::APB_AW-1:2] == mcpt_pkg::REG_TICK_MS) begin
			tick_ms_q <= pwdata[mcpt_pkg::TICK_W-1:0];
		end
	end

	// slot ring: head is cell 0, processed record re-enters at the tail
	assign shift = (state_q == S_WALK);
	assign head  = cell_q[0];

	for (genvar g = 0; g < mcpt_pkg::NUM_TIMERS; g++) begin : g_cell
		mcpt_pkg::slot_t d_in;
		if (g == mcpt_pkg::NUM_TIMERS - 1) begin : g_tail
			assign d_in = nxt;
		end else begin : g_mid
			assign d_in = cell_q[g+1];
		end
		mcpt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (shift),
			.d      (d_in),
			.q      (cell_q[g])
		);
	end

	assign cmd.ready = (state_q == S_IDLE);
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign div_start = cmd_acc && (cmd.op == mcpt_pkg::OP_ARM || cmd.op == mcpt_pkg::OP_EXEC_NOW);

	mcpt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (cmd.period_ms),
		.divisor  (tick_ms_q),
		.done     (div_done),
		.quotient (quot)
	);

	always_comb begin
		nxt       = head;
		expire    = 1'b0;
		hit_ok    = 1'b0;
		hit_armed = 1'b0;
		sel       = (32'(id_q) == 32'(step_q));
		dec       = head.rem - 1'b1;
		reps_dec  = head.reps - 1'b1;
		if (op_q == mcpt_pkg::OP_TICK) begin
			if (head.active && !head.paused) begin
				nxt.rem = dec;
				if (dec == '0) begin
					expire = 1'b1;
					if (head.reps == '0) begin
						nxt.rem = head.base;
					end else begin
						nxt.reps = reps_dec;
						if (reps_dec == '0) begin
							nxt.active = 1'b0;
							nxt.paused = 1'b0;
						end else begin
							nxt.rem = head.base;
						end
					end
				end
			end
		end else if (sel) begin
			unique case (op_q)
				mcpt_pkg::OP_ARM: begin
					nxt.base   = ticks_q;
					nxt.rem    = fire_q ? mcpt_pkg::PERIOD_W'(1) : ticks_q;
					nxt.reps   = reps_q;
					nxt.active = 1'b1;
					nxt.paused = 1'b0;
					hit_ok     = 1'b1;
				end
				mcpt_pkg::OP_DISARM: begin
					if (head.active) begin
						nxt.active = 1'b0;
						nxt.paused = 1'b0;
						hit_ok     = 1'b1;
					end
				end
				mcpt_pkg::OP_PAUSE, mcpt_pkg::OP_RESUME: begin
					if (head.active) begin
						nxt.paused = (op_q == mcpt_pkg::OP_PAUSE);
						hit_ok     = 1'b1;
					end
				end
				mcpt_pkg::OP_EXEC_NOW: begin
					if (head.active) nxt.rem = ticks_q;
					hit_ok = 1'b1;
				end
				mcpt_pkg::OP_QUERY: begin
					hit_ok    = head.active;
					hit_armed = head.active;
				end
				default: begin
				end
			endcase
		end
	end

	assign nmask = mask_q & (mask_q - 1'b1);
	assign nidx  = lowest_idx(mask_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
			op_q        <= mcpt_pkg::OP_TICK;
			id_q        <= '0;
			reps_q      <= '0;
			fire_q      <= 1'b0;
			ticks_q     <= '0;
			step_q      <= '0;
			cnt_q       <= '0;
			mask_q      <= '0;
			ok_q        <= 1'b0;
			armed_q     <= 1'b0;
			qrem_q      <= '0;
			prod_q      <= '0;
			kind_q      <= mcpt_pkg::KIND_REPLY;
			rid_q       <= '0;
			rok_q       <= 1'b0;
			rarmed_q    <= 1'b0;
			rrem_q      <= '0;
			rcnt_q      <= '0;
			rlast_q     <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_acc) begin
						op_q    <= cmd.op;
						id_q    <= cmd.timer_id;
						reps_q  <= cmd.repeat_count;
						fire_q  <= cmd.fire_now;
						step_q  <= '0;
						cnt_q   <= '0;
						mask_q  <= '0;
						ok_q    <= 1'b0;
						armed_q <= 1'b0;
						qrem_q  <= '0;
						state_q <= div_start ? S_DIV : S_WALK;
					end
				end
				S_DIV: begin
					if (div_done) begin
						ticks_q <= (quot == '0) ? mcpt_pkg::PERIOD_W'(1) : quot;
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					step_q <= step_q + 1'b1;
					cnt_q  <= cnt_q + mcpt_pkg::CNT_W'(nxt.active);
					if (expire) mask_q[step_q] <= 1'b1;
					if (sel && op_q != mcpt_pkg::OP_TICK) begin
						ok_q    <= hit_ok;
						armed_q <= hit_armed;
						qrem_q  <= hit_armed ? head.rem : '0;
					end
					if (step_q == mcpt_pkg::IDX_W'(mcpt_pkg::NUM_TIMERS - 1)) state_q <= S_MUL;
				end
				S_MUL: begin
					prod_q  <= qrem_q * tick_ms_q;
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					res_valid_q <= 1'b1;
					rcnt_q      <= cnt_q;
					rok_q       <= 1'b0;
					rarmed_q    <= 1'b0;
					rrem_q      <= '0;
					if (op_q == mcpt_pkg::OP_TICK) begin
						if (mask_q == '0) begin
							kind_q  <= mcpt_pkg::KIND_EMPTY;
							rid_q   <= '0;
							rlast_q <= 1'b1;
						end else begin
							kind_q  <= mcpt_pkg::KIND_EXPIRE;
							rid_q   <= mcpt_pkg::ID_W'(nidx);
							rlast_q <= (nmask == '0);
							mask_q  <= nmask;
						end
					end else begin
						kind_q   <= mcpt_pkg::KIND_REPLY;
						rid_q    <= id_q;
						rok_q    <= ok_q;
						rarmed_q <= armed_q;
						rrem_q   <= (prod_q[mcpt_pkg::PERIOD_W+mcpt_pkg::TICK_W-1:mcpt_pkg::PERIOD_W]
							!= '0) ? '1 : prod_q[mcpt_pkg::REM_MS_W-1:0];
						rlast_q  <= 1'b1;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (res.ready) begin
						if (op_q == mcpt_pkg::OP_TICK && mask_q != '0) begin
							kind_q  <= mcpt_pkg::KIND_EXPIRE;
							rid_q   <= mcpt_pkg::ID_W'(nidx);
							rlast_q <= (nmask == '0);
							mask_q  <= nmask;
						end else begin
							res_valid_q <= 1'b0;
							state_q     <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res.valid        = res_valid_q;
	assign res.kind         = kind_q;
	assign res.timer_id_res = rid_q;
	assign res.ok           = rok_q;
	assign res.armed        = rarmed_q;
	assign res.remaining_ms = rrem_q;
	assign res.active_count = rcnt_q;
	assign res.last         = rlast_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> !cmd.ready)
		else $error("input taken while an item is in progress");

	a_last_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.ready && res.last |=> !res.valid)
		else $error("result after the last one of an item");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ready |-> !res.valid)
		else $error("ready for input while a result is pending");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> res.active_count <= mcpt_pkg::CNT_W'(mcpt_pkg::NUM_TIMERS))
		else $error("active count exceeds number of slots");

endmodule

`default_nettype wire
